// ----- sv/ack_tracked_event_queue_assert.svh -----
// Assertion macros for the event queue
`ifndef ACK_TRACKED_EVENT_QUEUE_ASSERT_SVH
`define ACK_TRACKED_EVENT_QUEUE_ASSERT_SVH
`define ATEQ_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("label failed");
`define ATEQ_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("label failed");
`endif

// ----- sv/ateq_pkg.sv -----
// Shared types and codes for the event queue
package ateq_pkg;
   localparam logic [2:0] CMD_ENQ = 3'd0;
   localparam logic [2:0] CMD_COMMIT = 3'd1;
   localparam logic [2:0] CMD_PEND = 3'd2;
   localparam logic [2:0] CMD_COMPACT = 3'd3;
   localparam logic [2:0] CMD_QUERY = 3'd4;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_STORE = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;
   localparam int MAX_RESULTS = 16;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_EMIT, S_WAIT, S_COUNT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request word
      logic scan_rst;  // zero index/write pointer/count
      logic step;      // process one entry
      logic fin;       // apply end-of-command update
      logic emit;      // load output register
      logic emit_last;
      logic emit_item;
      logic cnt_rst;
      logic cnt_step;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_end;  // index reached occupancy, or command does not scan
      logic hit;       // current entry matches command
      logic stop;      // result gathered, stop scan
      logic cnt_end;
   } sts_type;
endpackage

// ----- sv/ateq_ctrl.sv -----
// Controller state machine for the event queue
module ateq_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic in_fire,
   input  logic [2:0] cmd,
   input  logic out_free,
   input  ateq_pkg::sts_type sts,
   output ateq_pkg::cmd_type ctl,
   output logic busy
);
   import ateq_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (in_fire) begin
               ctl.load = 1'b1;
               ctl.scan_rst = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cmd == CMD_PEND && sts.hit && !sts.scan_end) begin
               state_in = S_EMIT;
            end else if (sts.scan_end || sts.stop) begin
               ctl.fin = 1'b1;
               ctl.cnt_rst = 1'b1;
               state_in = S_COUNT;
            end else begin
               ctl.step = 1'b1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               ctl.emit = 1'b1;
               ctl.emit_item = 1'b1;
               ctl.emit_last = sts.stop;
               ctl.step = 1'b1;
               state_in = sts.stop ? S_IDLE : S_SCAN;
            end
         end
         S_COUNT: begin
            if (sts.cnt_end) state_in = S_WAIT;
            else ctl.cnt_step = 1'b1;
         end
         S_WAIT: begin
            if (out_free) begin
               ctl.emit = 1'b1;
               ctl.emit_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ----- sv/ateq_dp.sv -----
// Datapath: entry storage, scan pointers and result register
module ateq_dp #(
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  ateq_pkg::cmd_type ctl,
   input  logic [2:0] cmd_in,
   input  logic [7:0] tag_in,
   input  logic [47:0] occ_in,
   input  logic [31:0] target_in,
   input  logic ok_in,
   input  logic [4:0] maxc_in,
   input  logic [47:0] now_in,
   input  logic rsp_take,
   output ateq_pkg::sts_type sts,
   output logic [2:0] cmd,
   output logic out_free,
   output logic out_valid,
   output logic [1:0] o_status,
   output logic [31:0] o_id,
   output logic [7:0] o_tag,
   output logic [47:0] o_time,
   output logic [47:0] o_age,
   output logic [4:0] o_pend,
   output logic o_item,
   output logic o_last
);
   import ateq_pkg::*;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [31:0] id_mem [DEPTH];
   logic [7:0] tag_mem [DEPTH];
   logic [47:0] time_mem [DEPTH];
   logic [DEPTH-1:0] done_ff;

   logic [2:0] cmd_ff;
   logic [7:0] tag_ff;
   logic [47:0] occ_ff, now_ff;
   logic [31:0] target_ff, nid_ff;
   logic ok_ff;
   logic [4:0] lim_ff;
   logic [CW-1:0] occup_ff, rd_ff, wr_ff, ci_ff, pcnt_ff;
   logic [4:0] n_ff;
   logic [1:0] st_ff;
   logic [31:0] rid_ff;
   logic [47:0] age_ff;
   logic [AW-1:0] ra, wa;
   logic cur_done;
   logic hit, full;

   logic ov_ff;
   logic [1:0] ost_ff;
   logic [31:0] oid_ff;
   logic [7:0] otag_ff;
   logic [47:0] otime_ff, oage_ff;
   logic [4:0] opend_ff;
   logic oitem_ff, olast_ff;

   assign cmd = cmd_ff;
   assign ra = rd_ff[AW-1:0];
   assign wa = wr_ff[AW-1:0];
   assign cur_done = done_ff[ra];
   assign full = (occup_ff >= CW'(DEPTH));

   always_comb begin
      hit = 1'b0;
      unique case (cmd_ff)
         CMD_COMMIT: hit = (id_mem[ra] == target_ff);
         CMD_PEND: hit = !cur_done;
         CMD_QUERY: hit = !cur_done && (time_mem[ra] != 48'd0);
         default: hit = 1'b0;
      endcase
   end

   assign sts.scan_end = (rd_ff >= occup_ff) || (cmd_ff == CMD_ENQ)
      || (cmd_ff > CMD_QUERY);
   assign sts.hit = hit;
   // pending list closes at the limit or at the last pending entry
   assign sts.stop = (cmd_ff == CMD_PEND)
      ? (hit && ((n_ff + 5'd1) >= lim_ff || (CW'(n_ff) + CW'(1)) >= pcnt_ff))
      : (hit && (cmd_ff == CMD_COMMIT || cmd_ff == CMD_QUERY));
   assign sts.cnt_end = (ci_ff >= occup_ff);
   assign out_free = !ov_ff || rsp_take;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= cmd_in;
         tag_ff <= tag_in;
         occ_ff <= occ_in;
         target_ff <= target_in;
         ok_ff <= ok_in;
         now_ff <= now_in;
         lim_ff <= (maxc_in == 5'd0) ? 5'd1
            : (maxc_in > 5'(MAX_RESULTS)) ? 5'(MAX_RESULTS) : maxc_in;
      end
      if (ctl.step && cmd_ff == CMD_COMPACT && !cur_done) begin
         id_mem[wa] <= id_mem[ra];
         tag_mem[wa] <= tag_mem[ra];
         time_mem[wa] <= time_mem[ra];
      end
      if (ctl.fin && cmd_ff == CMD_ENQ && !full && ok_ff) begin
         id_mem[occup_ff[AW-1:0]] <= nid_ff;
         tag_mem[occup_ff[AW-1:0]] <= tag_ff;
         time_mem[occup_ff[AW-1:0]] <= occ_ff;
      end
      if (ctl.fin) begin
         unique case (cmd_ff)
            CMD_ENQ: begin
               st_ff <= full ? ST_FULL : (ok_ff ? ST_OK : ST_STORE);
               rid_ff <= full ? 32'd0 : nid_ff;
               age_ff <= 48'd0;
            end
            CMD_COMMIT: begin
               rid_ff <= target_ff;
               st_ff <= !hit || sts.scan_end ? ST_NOTFOUND
                  : (cur_done ? ST_OK : (ok_ff ? ST_OK : ST_STORE));
               age_ff <= 48'd0;
            end
            CMD_QUERY: begin
               rid_ff <= 32'd0;
               st_ff <= ST_OK;
               age_ff <= (hit && !sts.scan_end && now_ff > time_mem[ra])
                  ? now_ff - time_mem[ra] : 48'd0;
            end
            default: begin
               rid_ff <= 32'd0;
               st_ff <= ST_OK;
               age_ff <= 48'd0;
            end
         endcase
      end
      if (ctl.emit) begin
         ost_ff <= ctl.emit_item ? ST_OK : st_ff;
         oid_ff <= ctl.emit_item ? id_mem[ra] : rid_ff;
         otag_ff <= ctl.emit_item ? tag_mem[ra] : 8'd0;
         otime_ff <= ctl.emit_item ? time_mem[ra] : 48'd0;
         oage_ff <= ctl.emit_item ? 48'd0 : age_ff;
         opend_ff <= 5'(pcnt_ff);
         oitem_ff <= ctl.emit_item;
         olast_ff <= ctl.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occup_ff <= '0;
         nid_ff <= 32'd1;
         done_ff <= '0;
         ov_ff <= 1'b0;
         rd_ff <= '0;
         wr_ff <= '0;
         n_ff <= '0;
         ci_ff <= '0;
         pcnt_ff <= '0;
      end else begin
         ov_ff <= ctl.emit || (ov_ff && !rsp_take);
         if (ctl.scan_rst) begin
            rd_ff <= '0;
            wr_ff <= '0;
            n_ff <= '0;
         end
         if (ctl.step) begin
            rd_ff <= rd_ff + CW'(1);
            if (cmd_ff == CMD_PEND && !cur_done) n_ff <= n_ff + 5'd1;
            if (cmd_ff == CMD_COMPACT && !cur_done) begin
               done_ff[wa] <= 1'b0;
               wr_ff <= wr_ff + CW'(1);
            end
         end
         if (ctl.fin) begin
            unique case (cmd_ff)
               CMD_ENQ: if (!full) begin
                  nid_ff <= nid_ff + 32'd1;
                  if (ok_ff) begin
                     done_ff[occup_ff[AW-1:0]] <= 1'b0;
                     occup_ff <= occup_ff + CW'(1);
                  end
               end
               CMD_COMMIT: if (hit && !sts.scan_end && ok_ff) done_ff[ra] <= 1'b1;
               CMD_COMPACT: occup_ff <= wr_ff;
               default: ;
            endcase
         end
         if (ctl.cnt_rst) begin
            ci_ff <= '0;
            pcnt_ff <= '0;
         end
         if (ctl.cnt_step) begin
            ci_ff <= ci_ff + CW'(1);
            if (!done_ff[ci_ff[AW-1:0]]) pcnt_ff <= pcnt_ff + CW'(1);
         end
      end
   end

   assign out_valid = ov_ff;
   assign o_status = ost_ff;
   assign o_id = oid_ff;
   assign o_tag = otag_ff;
   assign o_time = otime_ff;
   assign o_age = oage_ff;
   assign o_pend = opend_ff;
   assign o_item = oitem_ff;
   assign o_last = olast_ff;
endmodule

// ----- sv/ack_tracked_event_queue.sv -----
// Acknowledgement-tracked event queue, top level
// The result word follows the scan of the entries and a recount of the pending ones.
// Get pending: each pending entry found by the scan is sent as an item word, waiting
// while the output register is held; the last item word ends the command.
// Commands are handled one at a time; no request is accepted while busy.
// Reset: queue empty, next id 1; entry storage is undefined until written.
module ack_tracked_event_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // cmd
   input  logic [2:0] req_tuser,
   // event_tag, occurred_ms, target_id, storage_ok, entry limit, now_ms
   input  logic [143:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // item_valid
   output logic rsp_tuser,
   // status, id, tag_out, time_out, age_ms, pending_total
   output logic [143:0] rsp_tdata,
   output logic rsp_tlast
);
   import ateq_pkg::*;
   cmd_type ctl;
   sts_type sts;
   logic busy, out_free, in_fire, out_valid;
   logic [2:0] cmd;
   logic [1:0] o_status;
   logic [31:0] o_id;
   logic [7:0] o_tag;
   logic [47:0] o_time, o_age;
   logic [4:0] o_pend;
   logic o_item, o_last;

   assign req_tready = !busy;
   assign in_fire = req_tvalid && req_tready;

   ateq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_fire(in_fire), .cmd(cmd),
      .out_free(out_free), .sts(sts), .ctl(ctl), .busy(busy)
   );

   ateq_dp #(.DEPTH(QUEUE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl),
      .cmd_in(req_tuser), .tag_in(req_tdata[7:0]),
      .occ_in(req_tdata[55:8]), .target_in(req_tdata[87:56]),
      .ok_in(req_tdata[88]), .maxc_in(req_tdata[93:89]),
      .now_in(req_tdata[141:94]), .rsp_take(rsp_tvalid && rsp_tready),
      .sts(sts), .cmd(cmd), .out_free(out_free), .out_valid(out_valid),
      .o_status(o_status), .o_id(o_id), .o_tag(o_tag), .o_time(o_time),
      .o_age(o_age), .o_pend(o_pend), .o_item(o_item), .o_last(o_last)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tlast = o_last;
   assign rsp_tuser = o_item;
   assign rsp_tdata = {1'b0, o_pend, o_age, o_time, o_tag, o_id, o_status};

`include "ack_tracked_event_queue_assert.svh"
   `ATEQ_ASSERT_IMPL(a_no_accept_busy, clock, reset, busy, !req_tready)
   `ATEQ_ASSERT_NEXT(a_accept_busy, clock, reset, in_fire, busy)
   `ATEQ_ASSERT_IMPL(a_pend_range, clock, reset, rsp_tvalid, int'(o_pend) <= QUEUE_DEPTH)
endmodule
